### src/warped_fir_filter_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the warped FIR filter
// Shorthand for the clocked checks used in the filter's RTL files.
// ----------------------------------------------------------------------------
`ifndef WARPED_FIR_FILTER_ASSERT_SVH
`define WARPED_FIR_FILTER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define WFF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("warped FIR same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define WFF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("warped FIR next-cycle check failed");

`endif

### src/wff_pkg.sv
// ----------------------------------------------------------------------------
// Warped FIR filter package
// Widths, codes, controller states, datapath commands and saturation helper.
// ----------------------------------------------------------------------------
package wff_pkg;

    // Defaults for the top-level parameters.
    localparam int MAX_TAPS_DEF    = 32;
    localparam int SAMPLE_BITS_DEF = 24;

    // Fixed field widths.
    localparam int VALUE_W    = 24;
    localparam int IDX_W      = 5;
    localparam int TAPS_W     = 6;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 24;
    localparam int TAPS_RST   = 32;

    // Internal arithmetic widths (Q.23 fixed point).
    localparam int STATE_W = 32;
    localparam int FRAC_W  = 23;
    localparam int PROD_W  = VALUE_W + STATE_W;
    localparam int RND_W   = PROD_W - FRAC_W;
    localparam int ACC_W   = 64;
    localparam int Q_W     = ACC_W + 1 - FRAC_W;

    // Item modes.
    typedef enum logic [0:0] {
        MODE_FILTER = 1'b0,
        MODE_COEF   = 1'b1
    } t_mode;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WARP = 1'b0,
        CFG_TAPS = 1'b1
    } t_cfg_reg;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADD,
        ST_FIN,
        ST_OUT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // start a new sample
        logic coef_wr;   // write a coefficient word
        logic rd_en;     // read state and coefficient memories
        logic mul;       // capture both products
        logic add;       // allpass update step
        logic wr_state;  // write back the previous section's state
        logic advance;   // accumulate and move to the next section
        logic fin;       // round and saturate the sum
        logic out_load;  // move the result into the output register
    } t_dp_cmd;

    // Saturate a 34-bit value to the 32-bit state range.
    function automatic logic signed [STATE_W-1:0] sat_state(
        input logic signed [STATE_W+1:0] v
    );
        logic [2:0] top;
        top = v[STATE_W+1:STATE_W-1];
        if (top == 3'b000 || top == 3'b111) begin
            return v[STATE_W-1:0];
        end else if (v[STATE_W+1]) begin
            return {1'b1, {(STATE_W-1){1'b0}}};
        end else begin
            return {1'b0, {(STATE_W-1){1'b1}}};
        end
    endfunction

endpackage

### src/wff_intf.sv
// ----------------------------------------------------------------------------
// Warped FIR filter channel interfaces
// Valid/ready channels for input words, result words and register writes.
// ----------------------------------------------------------------------------

// Input word: a sample to filter or a coefficient to store.
interface wff_in_if import wff_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               mode;
    logic [IDX_W-1:0]   coeff_index;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output mode, output coeff_index, output value,
                    input ready);
    modport sink   (input valid, input mode, input coeff_index, input value,
                    output ready);
endinterface

// Result word: one filtered sample.
interface wff_out_if import wff_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] output_sample;

    modport source (output valid, output output_sample, input ready);
    modport sink   (input valid, input output_sample, output ready);
endinterface

// Register write word.
interface wff_cfg_if import wff_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### src/wff_ctrl.sv
// ----------------------------------------------------------------------------
// Warped FIR filter controller
// Sequences the per-section multiply and add steps and the output handshake.
// ----------------------------------------------------------------------------
`include "warped_fir_filter_assert.svh"

module wff_ctrl import wff_pkg::*; #(
    parameter int MAX_TAPS = MAX_TAPS_DEF,
    parameter int CNT_W    = $clog2(MAX_TAPS + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_mode,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  logic [CNT_W-1:0] i_active_taps,
    output t_dp_cmd          o_cmd,
    output logic [CNT_W-1:0] o_tap,
    output logic [CNT_W-1:0] o_rd_tap
);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_tap, n_tap;
    logic             r_out_valid;
    logic             in_fire;
    logic             out_free;

    assign in_fire  = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;

    // Next state and section counter.
    always_comb begin
        n_state = r_state;
        n_tap   = r_tap;
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire && i_mode == MODE_FILTER) begin
                    n_tap   = '0;
                    n_state = (i_active_taps == '0) ? ST_FIN : ST_MUL;
                end
            end
            ST_MUL: begin
                n_state = ST_ADD;
            end
            ST_ADD: begin
                if (r_tap == i_active_taps) begin
                    n_state = ST_FIN;
                end else begin
                    n_tap   = r_tap + 1'b1;
                    n_state = ST_MUL;
                end
            end
            ST_FIN: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Datapath commands and input handshake.
    always_comb begin
        o_cmd      = '0;
        o_rd_tap   = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.rd_en   = 1'b1;
                o_cmd.load    = in_fire && i_mode == MODE_FILTER;
                o_cmd.coef_wr = in_fire && i_mode == MODE_COEF;
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
            end
            ST_ADD: begin
                o_cmd.add      = 1'b1;
                o_cmd.wr_state = r_tap != '0;
                o_cmd.advance  = r_tap != i_active_taps;
                o_cmd.rd_en    = 1'b1;
                o_rd_tap       = r_tap + 1'b1;
            end
            ST_FIN: begin
                o_cmd.fin = 1'b1;
            end
            ST_OUT: begin
                o_cmd.out_load = out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    assign o_tap       = r_tap;
    assign o_out_valid = r_out_valid;

    // State, counter and output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_tap       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_tap   <= n_tap;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // A filter word starts the section loop at section zero.
    `WFF_ASSERT_NEXT(a_start, i_clk, i_rst_n, in_fire && i_mode == MODE_FILTER, (r_state == ST_MUL || r_state == ST_FIN) && r_tap == '0)
    // Each non-final add step moves to the next section.
    `WFF_ASSERT_NEXT(a_step, i_clk, i_rst_n, r_state == ST_ADD && r_tap != i_active_taps, r_state == ST_MUL && r_tap == $past(r_tap) + 1'b1)
    // Loading the output leaves a valid word and returns to idle.
    `WFF_ASSERT_NEXT(a_out, i_clk, i_rst_n, r_state == ST_OUT && out_free, r_state == ST_IDLE && r_out_valid)
    // A start or coefficient write never overlaps arithmetic commands.
    `WFF_ASSERT_SAME(a_excl, i_clk, i_rst_n, o_cmd.load || o_cmd.coef_wr, !(o_cmd.mul || o_cmd.add || o_cmd.fin))

endmodule

### src/wff_dp.sv
// ----------------------------------------------------------------------------
// Warped FIR filter datapath
// Registers, state and coefficient memories, multipliers and accumulator.
// ----------------------------------------------------------------------------
module wff_dp import wff_pkg::*; #(
    parameter int MAX_TAPS    = MAX_TAPS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int CNT_W       = $clog2(MAX_TAPS + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    input  logic [CNT_W-1:0]      i_tap,
    input  logic [CNT_W-1:0]      i_rd_tap,
    input  logic [IDX_W-1:0]      i_coeff_index,
    input  logic [VALUE_W-1:0]    i_value,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic [CNT_W-1:0]      o_active_taps,
    output logic [VALUE_W-1:0]    o_out_sample
);

    localparam int TAP_W = $clog2(MAX_TAPS);
    localparam int CAP   = (MAX_TAPS / 4) * 4;
    localparam int CMP_W = (CNT_W > TAPS_W) ? CNT_W : TAPS_W;
    localparam logic signed [PROD_W-1:0] P_HALF = PROD_W'(1) <<< (FRAC_W - 1);
    localparam logic signed [ACC_W:0]    A_HALF = (ACC_W + 1)'(1) <<< (FRAC_W - 1);
    localparam logic signed [Q_W-1:0]    SAT_HI =
        Q_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [Q_W-1:0]    SAT_LO = ~SAT_HI;

    // Configuration registers.
    logic signed [VALUE_W-1:0] r_lam;
    logic [TAPS_W-1:0]         r_taps;

    // Memories and their valid flags.
    logic [STATE_W-1:0] r_state_mem [MAX_TAPS];
    logic [VALUE_W-1:0] r_coef_mem  [MAX_TAPS];
    logic [MAX_TAPS-1:0] r_state_vld;
    logic [MAX_TAPS-1:0] r_coef_vld;
    logic [STATE_W-1:0] r_s_rd;
    logic [VALUE_W-1:0] r_c_rd;
    logic               r_s_ok;
    logic               r_c_ok;

    // Working registers.
    logic signed [STATE_W-1:0] r_a_cur;
    logic signed [STATE_W-1:0] r_a_prev;
    logic signed [PROD_W-1:0]  r_p_lam;
    logic signed [PROD_W-1:0]  r_p_coef;
    logic signed [ACC_W-1:0]   r_acc;
    logic [VALUE_W-1:0]        r_res;
    logic [VALUE_W-1:0]        r_out_data;

    logic [TAP_W-1:0]          rd_addr;
    logic [TAP_W-1:0]          wr_addr;
    logic [CNT_W-1:0]          tap_prev;
    logic [TAP_W-1:0]          coef_addr;
    logic                      coef_ok;
    logic [CMP_W-1:0]          taps_x;
    logic [CMP_W-1:0]          cap_x;
    logic [CMP_W-1:0]          taps_min;
    logic signed [STATE_W-1:0] s_old;
    logic signed [VALUE_W-1:0] c_val;
    logic signed [PROD_W-1:0]  p_lam_rnd;
    logic signed [RND_W-1:0]   lam_r;
    logic signed [STATE_W+1:0] next_sum;
    logic signed [STATE_W+1:0] diff;
    logic signed [STATE_W-1:0] a_next;
    logic signed [STATE_W-1:0] s_new;
    logic signed [ACC_W:0]     acc_rnd;
    logic signed [Q_W-1:0]     q_val;
    logic signed [Q_W-1:0]     q_sat;

    // Active section count: capped and rounded down to a multiple of four.
    assign taps_x        = CMP_W'(r_taps);
    assign cap_x         = CMP_W'(CAP);
    assign taps_min      = (taps_x > cap_x) ? cap_x : taps_x;
    assign o_active_taps = CNT_W'({taps_min[CMP_W-1:2], 2'b00});

    // Memory addresses.
    assign rd_addr   = i_rd_tap[TAP_W-1:0];
    assign tap_prev  = i_tap - 1'b1;
    assign wr_addr   = tap_prev[TAP_W-1:0];
    assign coef_addr = TAP_W'(i_coeff_index);
    assign coef_ok   = i_cmd.coef_wr && (int'(i_coeff_index) < MAX_TAPS);

    // Entries never written read as zero.
    assign s_old = r_s_ok ? r_s_rd : '0;
    assign c_val = r_c_ok ? r_c_rd : '0;

    // Allpass step: one rounded lambda product feeds both the next section
    // input and the previous section's state update.
    assign p_lam_rnd = r_p_lam + P_HALF;
    assign lam_r     = p_lam_rnd[PROD_W-1:FRAC_W];
    assign next_sum  = $signed({{2{s_old[STATE_W-1]}}, s_old})
                     + $signed({lam_r[RND_W-1], lam_r});
    assign diff      = $signed({{2{r_a_prev[STATE_W-1]}}, r_a_prev})
                     - $signed({lam_r[RND_W-1], lam_r});
    assign a_next    = sat_state(next_sum);
    assign s_new     = sat_state(diff);

    // Final rounding and saturation of the sum.
    assign acc_rnd = $signed({r_acc[ACC_W-1], r_acc}) + A_HALF;
    assign q_val   = acc_rnd[ACC_W:FRAC_W];
    always_comb begin
        priority if (q_val > SAT_HI) begin
            q_sat = SAT_HI;
        end else if (q_val < SAT_LO) begin
            q_sat = SAT_LO;
        end else begin
            q_sat = q_val;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lam  <= '0;
            r_taps <= TAPS_W'(TAPS_RST);
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                CFG_WARP: r_lam  <= i_cfg_data[VALUE_W-1:0];
                CFG_TAPS: r_taps <= i_cfg_data[TAPS_W-1:0];
            endcase
        end
    end

    // Memory arrays with registered reads.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_state) begin
            r_state_mem[wr_addr] <= s_new;
        end
        if (coef_ok) begin
            r_coef_mem[coef_addr] <= i_value;
        end
        if (i_cmd.rd_en) begin
            r_s_rd <= r_state_mem[rd_addr];
            r_c_rd <= r_coef_mem[rd_addr];
        end
    end

    // Valid flags: reset clears every entry at once.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state_vld <= '0;
            r_coef_vld  <= '0;
            r_s_ok      <= 1'b0;
            r_c_ok      <= 1'b0;
        end else begin
            if (i_cmd.wr_state) begin
                r_state_vld[wr_addr] <= 1'b1;
            end
            if (coef_ok) begin
                r_coef_vld[coef_addr] <= 1'b1;
            end
            if (i_cmd.rd_en) begin
                r_s_ok <= r_state_vld[rd_addr];
                r_c_ok <= r_coef_vld[rd_addr];
            end
        end
    end

    // Sample, products, accumulator and result.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_a_cur <= $signed({{(STATE_W-VALUE_W){i_value[VALUE_W-1]}}, i_value});
            r_acc   <= '0;
        end
        if (i_cmd.mul) begin
            r_p_lam  <= r_lam * r_a_cur;
            r_p_coef <= c_val * r_a_cur;
        end
        if (i_cmd.add && i_cmd.advance) begin
            r_acc    <= r_acc + $signed({{(ACC_W-PROD_W){r_p_coef[PROD_W-1]}}, r_p_coef});
            r_a_prev <= r_a_cur;
            r_a_cur  <= a_next;
        end
        if (i_cmd.fin) begin
            r_res <= q_sat[VALUE_W-1:0];
        end
        if (i_cmd.out_load) begin
            r_out_data <= r_res;
        end
    end

    assign o_out_sample = r_out_data;

endmodule

### src/warped_fir_filter.sv
// ----------------------------------------------------------------------------
// Warped FIR filter top level
// Sequence: an accepted filter word runs a multiply step then an add step for
// each allpass section from zero up to the active tap count, then a finish
// step and an output step; with no active taps it skips to the finish step.
// Coefficient words are taken one per cycle while idle and give no result word.
// A new filter word is taken only after the last result is loaded out.
// Synchronous active-low reset makes allpass states and coefficients read as
// zero, sets lambda to zero and the tap count to 32, and empties the output.
// ----------------------------------------------------------------------------
module warped_fir_filter import wff_pkg::*; #(
    parameter int MAX_TAPS    = MAX_TAPS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    wff_in_if.sink    i_in,
    wff_out_if.source o_out,
    wff_cfg_if.sink   i_cfg
);

    localparam int CNT_W = $clog2(MAX_TAPS + 1);

    t_dp_cmd          cmd;
    logic [CNT_W-1:0] tap;
    logic [CNT_W-1:0] rd_tap;
    logic [CNT_W-1:0] active_taps;
    logic             in_ready;
    logic             out_valid;
    logic [VALUE_W-1:0] out_sample;

    // Register writes are always taken.
    assign i_cfg.ready = 1'b1;

    assign i_in.ready          = in_ready;
    assign o_out.valid         = out_valid;
    assign o_out.output_sample = out_sample;

    // Controller.
    wff_ctrl #(
        .MAX_TAPS (MAX_TAPS),
        .CNT_W    (CNT_W)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in.valid),
        .o_in_ready    (in_ready),
        .i_mode        (i_in.mode),
        .o_out_valid   (out_valid),
        .i_out_ready   (o_out.ready),
        .i_active_taps (active_taps),
        .o_cmd         (cmd),
        .o_tap         (tap),
        .o_rd_tap      (rd_tap)
    );

    // Datapath.
    wff_dp #(
        .MAX_TAPS    (MAX_TAPS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .CNT_W       (CNT_W)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_tap         (tap),
        .i_rd_tap      (rd_tap),
        .i_coeff_index (i_in.coeff_index),
        .i_value       (i_in.value),
        .i_cfg_we      (i_cfg.valid),
        .i_cfg_idx     (i_cfg.index),
        .i_cfg_data    (i_cfg.data),
        .o_active_taps (active_taps),
        .o_out_sample  (out_sample)
    );

endmodule
